// ===== design/rdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the radix digit converter.
// Has no dependencies; every other design file imports it.
package rdc_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 31;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    // Radix limits and reset value.
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // Long division works on a padded word, a fixed number of bits per cycle.
    localparam int WORK_W     = 32;
    localparam int STEP_BITS  = 8;
    localparam int NUM_CHUNKS = WORK_W / STEP_BITS;
    localparam int CHUNK_W    = $clog2(NUM_CHUNKS);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // ASCII anchors for digit characters.
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 4'd10;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               is_zero;
    } item_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } back_state_t;

    // Clamp a raw register value into the legal radix range.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Map a digit value to its ASCII character, 0-9 then A-F.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end else begin
            c = CHAR_UPPER_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_LIMIT};
        end
        return c;
    endfunction

endpackage

// ===== design/rdc_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the radix register, accepts requests and classifies them.
// Depends on rdc_pkg.
module rdc_front
    import rdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               item_valid,
    input  logic               item_ready,
    output item_t              item
);

    logic [RADIX_W-1:0] radix_reg;

    // Radix register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // Classify the request and hand it to the queue.
    assign item_valid   = in_valid;
    assign in_ready     = item_ready;
    assign item.value   = value;
    assign item.radix   = clamp_radix(radix_reg);
    assign item.is_zero = (value == '0);

endmodule

// ===== design/rdc_queue.sv =====
`timescale 1ns / 1ps
// Short request queue that decouples the front end from the back end.
// Depends on rdc_pkg for the item type and depth.
module rdc_queue
    import rdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/rdc_back.sv =====
`timescale 1ns / 1ps
// Back end: divides by the radix a chunk of bits per cycle, pushes remainders
// on the digit stack, then pops them to the output register. Depends on rdc_pkg.
module rdc_back
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGIT_W-1:0] digit,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    back_state_t          state_reg, state_next;
    logic [WORK_W-1:0]    work_reg, work_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [CW-1:0]        sp_reg, sp_next;

    logic [DIGIT_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DIGIT_W-1:0]   rd_data_reg;
    logic                 push_en;
    logic [DIGIT_W-1:0]   push_data;
    logic                 rd_en;
    logic [CW-1:0]        sp_dec;

    logic                 out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]   digit_reg;
    logic                 last_reg;
    logic                 out_load;

    logic [RADIX_W-1:0]   div_rem;
    logic [STEP_BITS-1:0] div_qbits;
    logic [WORK_W-1:0]    div_quot;

    // One chunk of restoring long division by a radix of at most sixteen.
    always_comb
    begin
        logic [RADIX_W-1:0] trial;
        div_rem   = {1'b0, rem_reg};
        div_qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {div_rem[DIGIT_W-1:0], work_reg[WORK_W-1-i]};
            if (trial >= radix_reg) begin
                div_rem                   = trial - radix_reg;
                div_qbits[STEP_BITS-1-i]  = 1'b1;
            end else begin
                div_rem = trial;
            end
        end
        div_quot = {work_reg[WORK_W-STEP_BITS-1:0], div_qbits};
    end

    assign sp_dec     = sp_reg - 1'b1;
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign item_ready = (state_reg == ST_IDLE);

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        chunk_next     = chunk_reg;
        sp_next        = sp_reg;
        push_en        = 1'b0;
        push_data      = '0;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    radix_next = item.radix;
                    if (item.is_zero) begin
                        // A zero value is the single digit zero.
                        push_en    = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        work_next  = {{(WORK_W-VALUE_W){1'b0}}, item.value};
                        rem_next   = '0;
                        chunk_next = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                work_next  = div_quot;
                rem_next   = div_rem[DIGIT_W-1:0];
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_W'(NUM_CHUNKS - 1)) begin
                    // Division done: push the remainder, restart on the quotient.
                    push_en   = 1'b1;
                    push_data = div_rem[DIGIT_W-1:0];
                    rem_next  = '0;
                    if (div_quot == '0) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (sp_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    sp_next    = sp_dec;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    if (sp_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        // Fetch the next digit while this one goes out.
                        rd_en   = 1'b1;
                        sp_next = sp_dec;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (push_en && (sp_reg < CW'(STACK_DEPTH))) begin
            sp_next = sp_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        if (out_load) begin
            digit_reg <= rd_data_reg;
            last_reg  <= (sp_reg == '0);
        end
    end

    // Digit stack memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (push_en && (sp_reg < CW'(STACK_DEPTH))) begin
            stack_mem[sp_reg[AW-1:0]] <= push_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[sp_dec[AW-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign digit_char = digit_to_char(digit_reg);
    assign last       = last_reg;

`ifndef SYNTH
    // The stack pointer never passes the stack depth.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(STACK_DEPTH))
        else $error("digit stack pointer out of range");

    // A new request starts only with an empty stack.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sp_reg == '0))
        else $error("stack not empty while idle");

    // The final digit returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (sp_reg == '0)) |=> (state_reg == ST_IDLE) && last_reg)
        else $error("final digit did not end the request");

    // The partial remainder stays below the radix.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < radix_reg))
        else $error("partial remainder not below radix");
`endif

endmodule

// ===== design/radix_digit_converter_core.sv =====
`timescale 1ns / 1ps
// A request yields D digits, 1 to 31.
// The back end divides 8 bits per cycle, then pops one digit a cycle while the output is not stalled.
// Only one request is in the back end at a time. A two-entry queue lets the front
// accept requests while the back end is busy.
// Reset clears control state and sets the radix to 10; the digit stack is not cleared.
module radix_digit_converter_core
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGIT_W-1:0] digit,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last
);

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    // Front end: radix register and request classification.
    rdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    // Decoupling queue.
    rdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // Back end: division, digit stack and output register.
    rdc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit      (digit),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

// ===== tb/radix_digit_converter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the radix digit converter: random-gap request and digit
// channels, a predictor of the digit sequence, and phases at several radix settings.
// Depends on rdc_pkg and radix_digit_converter_core.
module radix_digit_converter_core_tb;
    import rdc_pkg::*;

    // One emitted digit as the block presents it.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [CHAR_W-1:0]  digit_char;
        logic               last;
    } digit_rec_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 43;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [RADIX_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;

    // Testbench state shared by the driver, the monitor and the sequencer.
    logic [VALUE_W-1:0] pending_values[$];
    digit_rec_t         expected_digits[$];
    digit_rec_t         oldest_digit;
    logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
    int                 queued_count = 0;
    int                 accepted_count = 0;
    int                 error_count = 0;
    int                 shown_count = 0;
    int                 send_gap = 0;
    int                 recv_gap = 0;
    int                 hold_left;
    logic               hold_done;
    logic               hold_armed = 1'b0;
    logic               burst_mode = 1'b0;

    radix_digit_converter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit      (digit),
        .digit_char (digit_char),
        .last       (last)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Expected digits of one value at the current radix, most significant first.
    task automatic predict_digits(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] stack [0:31];
        int                 depth;
        int unsigned        n;
        int unsigned        r;
        digit_rec_t         rec;
        r = radix_shadow;
        if (r < 2)
            r = 2;
        else if (r > 16)
            r = 16;
        n = v;
        depth = 0;
        if (n == 0)
        begin
            stack[0] = '0;
            depth = 1;
        end
        else
        begin
            while (n != 0)
            begin
                stack[depth] = DIGIT_W'(n % r);
                depth++;
                n = n / r;
            end
        end
        for (int i = depth - 1; i >= 0; i--)
        begin
            rec.digit = stack[i];
            if (stack[i] < 4'd10)
                rec.digit_char = CHAR_ZERO + CHAR_W'(stack[i]);
            else
                rec.digit_char = CHAR_UPPER_A + CHAR_W'(stack[i] - 4'd10);
            rec.last = (i == 0);
            expected_digits.push_back(rec);
        end
    endtask

    // Request driver: predicts each accepted request, then offers the next pending one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_digits(value);
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_values.size() != 0)
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                    send_gap = burst_mode ? 0 : pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once when armed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Digit monitor: checks each accepted digit against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    error_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("unexpected digit: digit %0d char %02h last %0b",
                                 digit, digit_char, last);
                    end
                end
                else
                begin
                    oldest_digit = expected_digits.pop_front();
                    if (digit !== oldest_digit.digit || digit_char !== oldest_digit.digit_char ||
                        last !== oldest_digit.last)
                    begin
                        error_count++;
                        if (shown_count < 10)
                        begin
                            shown_count++;
                            $display("digit mismatch: expected %0d/%02h/%0b got %0d/%02h/%0b",
                                     oldest_digit.digit, oldest_digit.digit_char,
                                     oldest_digit.last, digit, digit_char, last);
                        end
                    end
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                out_ready <= 1'b0;
                recv_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!burst_mode && $urandom_range(0, 3) == 0)
                    recv_gap = pick_gap();
            end
        end
    end

    // Writes the radix register through its own channel and mirrors it.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        radix_shadow = r;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        queued_count++;
    endtask

    // Waits until every queued request is taken and every digit has come back.
    task automatic drain_phase();
        do
            @(posedge clk);
        while (accepted_count != queued_count || expected_digits.size() != 0);
    endtask

    // Sequencer: directed cases, then random phases at varying radix settings.
    initial
    begin
        logic [RADIX_W-1:0] r;
        logic [VALUE_W-1:0] v;
        int unsigned        r_eff;
        int unsigned        w;
        longint unsigned    p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radix of ten: extremes and alternating bit patterns.
        queue_value(31'd0);
        queue_value(31'd1);
        queue_value(31'd9);
        queue_value(31'd10);
        queue_value(31'd1234567890);
        queue_value(31'h7FFFFFFF);
        queue_value(31'h55555555);
        queue_value(31'h2AAAAAAA);
        drain_phase();

        // Binary gives the longest digit strings.
        write_radix(5'd2);
        queue_value(31'd0);
        queue_value(31'h7FFFFFFF);
        queue_value(31'd1);
        drain_phase();

        // Hexadecimal covers the letter digits.
        write_radix(5'd16);
        queue_value(31'h7FFFFFFF);
        queue_value(31'h0ABCDEF);
        queue_value(31'd15);
        drain_phase();

        // Register values below two and above sixteen are clamped; then radix three at the largest value.
        write_radix(5'd0);
        queue_value(31'd5);
        drain_phase();
        write_radix(5'd1);
        queue_value(31'd6);
        drain_phase();
        write_radix(5'd17);
        queue_value(31'd255);
        drain_phase();
        write_radix(5'd31);
        queue_value(31'h7EDCBA98);
        drain_phase();
        write_radix(5'd3);
        queue_value(31'h7FFFFFFF);
        drain_phase();

        // Random phases; the first one runs without gaps under a long output stall.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                r = 5'd2;
            else if (ph == 1)
                r = 5'd16;
            else if ($urandom_range(0, 9) < 7)
                r = RADIX_W'($urandom_range(2, 16));
            else
                r = RADIX_W'($urandom_range(0, 31));
            write_radix(r);
            r_eff = r;
            if (r_eff < 2)
                r_eff = 2;
            else if (r_eff > 16)
                r_eff = 16;
            @(posedge clk);
            burst_mode <= (ph == 0) || ($urandom_range(0, 3) == 0);
            if (ph == 0)
                hold_armed <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = VALUE_W'($urandom);
                    4: v = '0;
                    5: v = '1;
                    6: v = VALUE_W'($urandom_range(0, 300));
                    7:
                    begin
                        // Near a power of the radix, where the digit count steps.
                        p = 1;
                        w = $urandom_range(1, 31);
                        for (int k = 0; k < w; k++)
                        begin
                            if (p * r_eff <= 64'h7FFFFFFF)
                                p = p * r_eff;
                        end
                        v = VALUE_W'(p - $urandom_range(0, 1));
                    end
                    8: v = VALUE_W'($urandom) >> $urandom_range(0, 30);
                    default: v = VALUE_W'(1) << $urandom_range(0, 30);
                endcase
                queue_value(v);
            end
            drain_phase();
        end

        // Let the block settle so that any stray digit is seen.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_digits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit.
    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rdc_pkg.sv
design/rdc_front.sv
design/rdc_queue.sv
design/rdc_back.sv
design/radix_digit_converter_core.sv
tb/radix_digit_converter_core_tb.sv
